// ----- src/kfai_pkg.sv -----
// Shared types and constants for the keyframe alpha interpolator.
// No dependencies; used by kfai_cfg_regs and keyframe_alpha_interpolator.

package kfai_pkg;

  // Field widths
  localparam int HOLD_W  = 24;
  localparam int FADE_W  = 24;
  localparam int LEVEL_W = 13;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 5;
  localparam int SEG_W   = 4;
  localparam int SLOT_W  = 4;

  // Q16 fraction: one integer bit plus sixteen fraction bits
  localparam int FRAC_W    = 17;
  localparam int DIV_STEPS = 17;
  localparam int STEP_W    = 5;

  // Register map (word index taken from paddr[2])
  localparam logic REG_KEY_COUNT = 1'b0;

  // Request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One stored key
  typedef struct packed {
    logic [HOLD_W-1:0]  hold;
    logic [FADE_W-1:0]  fade;
    logic [LEVEL_W-1:0] level;
  } key_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_HOLD  = 9'b000000100,
    ST_FADE  = 9'b000001000,
    ST_RDB   = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_BLEND = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

endpackage

// ----- src/keyframe_alpha_interpolator.sv -----
// Top level of the keyframe alpha interpolator: key table, walk sequencer,
// shared subtractor, divider steps and blend. Depends on kfai_pkg and kfai_cfg_regs.

// A write request stores one key when it is accepted. A query request walks the
// keys from slot 0 through one shared 33-bit subtractor: each key visited
// takes a table read, a hold compare and a fade compare. A query that lands
// inside a fade before the last key, with a nonzero fade, then adds a table
// read of the next key, 17 restoring-division steps on the same subtractor for
// the Q16 fraction, one multiply and one rounding add. The block takes a new
// request only when the sequencer is idle; a finished result sits in the
// output register and does not stop the next request from being taken. The key
// table is not cleared by reset: query only keys that were written.

module keyframe_alpha_interpolator #(
  parameter int MAX_KEYS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [kfai_pkg::SLOT_W-1:0]   in_key_index,
  input  logic [kfai_pkg::HOLD_W-1:0]   in_hold_time,
  input  logic [kfai_pkg::FADE_W-1:0]   in_fade_time,
  input  logic [kfai_pkg::LEVEL_W-1:0]  in_key_level,
  input  logic [kfai_pkg::TIME_W-1:0]   in_query_time,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kfai_pkg::LEVEL_W-1:0]  out_level_out,
  output logic [kfai_pkg::SEG_W-1:0]    out_segment,
  output logic                          out_in_fade,
  output logic                          out_past_end,
  output logic                          out_empty_error,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = (IW + 1 > kfai_pkg::COUNT_W) ? IW + 1 : kfai_pkg::COUNT_W;
  localparam int LW = kfai_pkg::LEVEL_W;

  // Configuration
  logic [kfai_pkg::COUNT_W-1:0] key_count;

  kfai_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_count (key_count)
  );

  // Active key count saturated to the table depth, and last index
  logic [CW-1:0] count_ext;
  logic [CW-1:0] n_keys;
  logic [IW-1:0] last_idx;

  assign count_ext = CW'(key_count);
  assign n_keys    = (count_ext > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : count_ext;
  assign last_idx  = IW'(n_keys - CW'(1));

  // Key table
  kfai_pkg::key_t key_mem [MAX_KEYS];
  kfai_pkg::key_t rd_data_r;
  kfai_pkg::key_t wr_data;
  logic [IW-1:0]  wr_addr;
  logic           slot_ok;
  logic           in_fire;
  logic           wr_en;

  assign in_fire = in_valid && in_ready;
  assign slot_ok = ({5'b0, in_key_index} < 9'(MAX_KEYS));
  assign wr_en   = in_fire && (in_mode == kfai_pkg::MODE_WRITE) && slot_ok;
  assign wr_addr = IW'(in_key_index);
  assign wr_data = '{hold: in_hold_time, fade: in_fade_time, level: in_key_level};

  // Sequencer and datapath registers
  kfai_pkg::state_t              state_r,   state_nxt;
  logic [kfai_pkg::TIME_W-1:0]   t_r,       t_nxt;
  logic [IW-1:0]                 idx_r,     idx_nxt;
  logic [IW-1:0]                 rd_addr_r, rd_addr_nxt;
  logic [LW-1:0]                 lvl_r,     lvl_nxt;
  logic [LW-1:0]                 lvl_a_r,   lvl_a_nxt;
  logic [kfai_pkg::FADE_W-1:0]   fade_r,    fade_nxt;
  logic [kfai_pkg::FADE_W:0]     rem_r,     rem_nxt;
  logic [kfai_pkg::FRAC_W-1:0]   quo_r,     quo_nxt;
  logic [kfai_pkg::STEP_W-1:0]   cnt_r,     cnt_nxt;
  logic signed [31:0]            prod_r,    prod_nxt;
  logic                          fading_r,  fading_nxt;
  logic                          past_r,    past_nxt;
  logic                          empty_r,   empty_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [LW-1:0]                 out_level_r;
  logic [kfai_pkg::SEG_W-1:0]    out_seg_r;
  logic                          out_fade_r;
  logic                          out_past_r;
  logic                          out_empty_r;
  logic                          out_load;

  // Write port and registered read port of the key table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= key_mem[rd_addr_r];
  end

  // Shared subtractor: hold and fade compares, then division steps
  logic [32:0]                 sub_a;
  logic [32:0]                 sub_b;
  logic [32:0]                 sub_d;
  logic                        sub_ge;
  logic                        sub_gt;
  logic [kfai_pkg::FADE_W:0]   dvd;

  assign dvd = (cnt_r == '0) ? rem_r : {rem_r[kfai_pkg::FADE_W-1:0], 1'b0};

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      kfai_pkg::ST_HOLD: begin
        sub_a = {1'b0, t_r};
        sub_b = 33'(rd_data_r.hold);
      end
      kfai_pkg::ST_FADE: begin
        sub_a = {1'b0, t_r};
        sub_b = 33'(rd_data_r.fade);
      end
      kfai_pkg::ST_DIV: begin
        sub_a = 33'(dvd);
        sub_b = 33'(fade_r);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_d  = sub_a - sub_b;
  assign sub_ge = !sub_d[32];
  assign sub_gt = sub_ge && (sub_d != '0);

  // Blend arithmetic
  logic signed [LW:0]   lvl_diff;
  logic signed [31:0]   prod_w;
  logic signed [31:0]   rnd;
  logic signed [LW+3:0] blend_sum;

  assign lvl_diff  = $signed({1'b0, rd_data_r.level}) - $signed({1'b0, lvl_a_r});
  assign prod_w    = 32'(lvl_diff * $signed({1'b0, quo_r}));
  assign rnd       = prod_r + 32'sd32768;
  assign blend_sum = $signed({4'b0, lvl_a_r}) + $signed(rnd[31:16]);

  // Output register is free when empty or being drained
  assign out_load = (state_r == kfai_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    t_nxt       = t_r;
    idx_nxt     = idx_r;
    rd_addr_nxt = rd_addr_r;
    lvl_nxt     = lvl_r;
    lvl_a_nxt   = lvl_a_r;
    fade_nxt    = fade_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    prod_nxt    = prod_r;
    fading_nxt  = fading_r;
    past_nxt    = past_r;
    empty_nxt   = empty_r;

    unique case (state_r)
      kfai_pkg::ST_IDLE: begin
        // Start a query; writes finish at the accept edge
        if (in_fire && (in_mode == kfai_pkg::MODE_QUERY)) begin
          t_nxt       = in_query_time;
          idx_nxt     = '0;
          rd_addr_nxt = '0;
          lvl_nxt     = '0;
          fading_nxt  = 1'b0;
          past_nxt    = 1'b0;
          empty_nxt   = (n_keys == '0);
          state_nxt   = (n_keys == '0) ? kfai_pkg::ST_DONE : kfai_pkg::ST_RD;
        end
      end
      kfai_pkg::ST_RD: begin
        state_nxt = kfai_pkg::ST_HOLD;
      end
      kfai_pkg::ST_HOLD: begin
        // Drop the hold, or stop inside it
        if (sub_gt) begin
          t_nxt     = sub_d[31:0];
          state_nxt = kfai_pkg::ST_FADE;
        end else begin
          lvl_nxt   = rd_data_r.level;
          state_nxt = kfai_pkg::ST_DONE;
        end
      end
      kfai_pkg::ST_FADE: begin
        if (sub_gt) begin
          // Past this key's fade: advance or run off the end
          t_nxt = sub_d[31:0];
          if (idx_r == last_idx) begin
            lvl_nxt   = rd_data_r.level;
            past_nxt  = 1'b1;
            state_nxt = kfai_pkg::ST_DONE;
          end else begin
            idx_nxt     = IW'(idx_r + 1'b1);
            rd_addr_nxt = IW'(idx_r + 1'b1);
            state_nxt   = kfai_pkg::ST_RD;
          end
        end else begin
          fading_nxt = 1'b1;
          lvl_nxt    = rd_data_r.level;
          if ((idx_r != last_idx) && (rd_data_r.fade != '0)) begin
            // Fetch the next key and set up the fraction division
            lvl_a_nxt   = rd_data_r.level;
            fade_nxt    = rd_data_r.fade;
            rem_nxt     = t_r[kfai_pkg::FADE_W:0];
            quo_nxt     = '0;
            cnt_nxt     = '0;
            rd_addr_nxt = IW'(idx_r + 1'b1);
            state_nxt   = kfai_pkg::ST_RDB;
          end else begin
            state_nxt = kfai_pkg::ST_DONE;
          end
        end
      end
      kfai_pkg::ST_RDB: begin
        state_nxt = kfai_pkg::ST_DIV;
      end
      kfai_pkg::ST_DIV: begin
        // One quotient bit per step
        rem_nxt = sub_ge ? sub_d[kfai_pkg::FADE_W:0] : dvd;
        quo_nxt = {quo_r[kfai_pkg::FRAC_W-2:0], sub_ge};
        cnt_nxt = kfai_pkg::STEP_W'(cnt_r + 1'b1);
        if (cnt_r == kfai_pkg::STEP_W'(kfai_pkg::DIV_STEPS - 1)) begin
          state_nxt = kfai_pkg::ST_MUL;
        end
      end
      kfai_pkg::ST_MUL: begin
        prod_nxt  = prod_w;
        state_nxt = kfai_pkg::ST_BLEND;
      end
      kfai_pkg::ST_BLEND: begin
        lvl_nxt   = blend_sum[LW-1:0];
        state_nxt = kfai_pkg::ST_DONE;
      end
      kfai_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = kfai_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kfai_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, clear once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfai_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    idx_r     <= idx_nxt;
    rd_addr_r <= rd_addr_nxt;
    lvl_r     <= lvl_nxt;
    lvl_a_r   <= lvl_a_nxt;
    fade_r    <= fade_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    prod_r    <= prod_nxt;
    fading_r  <= fading_nxt;
    past_r    <= past_nxt;
    empty_r   <= empty_nxt;
    if (out_load) begin
      out_level_r <= lvl_r;
      out_seg_r   <= kfai_pkg::SEG_W'(idx_r);
      out_fade_r  <= fading_r;
      out_past_r  <= past_r;
      out_empty_r <= empty_r;
    end
  end

  assign in_ready        = (state_r == kfai_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_level_out   = out_level_r;
  assign out_segment     = out_seg_r;
  assign out_in_fade     = out_fade_r;
  assign out_past_end    = out_past_r;
  assign out_empty_error = out_empty_r;

  // A result appears only when the sequencer finishes a query
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == kfai_pkg::ST_DONE))
    else $error("result appeared without a finished query");

  // An empty-table result carries no level and no position flags
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_error) |->
      (out_level_out == '0) && !out_in_fade && !out_past_end && (out_segment == '0))
    else $error("empty-table result carries data");

  // A time cannot be both inside a fade and past the last key
  a_fade_past_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_in_fade && out_past_end))
    else $error("fade and past-end flags both set");

  // The division always runs its full step count before the multiply
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kfai_pkg::ST_MUL) |->
      $past(cnt_r == kfai_pkg::STEP_W'(kfai_pkg::DIV_STEPS - 1)))
    else $error("multiply entered before the division finished");

endmodule

// ----- src/kfai_cfg_regs.sv -----
// APB-style configuration register file for the keyframe alpha interpolator.
// Holds key_count; depends on kfai_pkg.

module kfai_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [kfai_pkg::COUNT_W-1:0]  key_count
);

  logic [kfai_pkg::COUNT_W-1:0] key_count_r;
  logic                         wr_en;

  // Complete every access without wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr[2] == kfai_pkg::REG_KEY_COUNT);

  // Hold the key count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (wr_en) begin
      key_count_r <= pwdata[kfai_pkg::COUNT_W-1:0];
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    if (paddr[2] == kfai_pkg::REG_KEY_COUNT) begin
      prdata = {{(32-kfai_pkg::COUNT_W){1'b0}}, key_count_r};
    end
  end

  assign key_count = key_count_r;

endmodule
